// ----- rtl/core/usbdfr_pkg.sv -----
// shared types and constants for the usb rx bundle deframer
package usbdfr_pkg;

    localparam int BUF_BYTES_DEF = 32768;
    localparam int MAX_ENTRIES   = 63;
    localparam int ENTRY_W       = 6;

    localparam logic [15:0] MAX_ENTRIES_V = 16'(MAX_ENTRIES);
    localparam logic [12:0] RUNT_MIN      = 13'd16;
    localparam logic [12:0] PAD_BYTES     = 13'd2;
    localparam logic [2:0]  L4_TYPE_TCP   = 3'b100;
    localparam logic [2:0]  L4_TYPE_UDP   = 3'b001;
    localparam logic [2:0]  WORD_BYTES    = 3'd4;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_TRAIL,
        ST_HDR,
        ST_ENTRY,
        ST_META,
        ST_EVAL,
        ST_STATUS
    } dfr_state_t;

    typedef struct packed {
        logic        drop_err;
        logic        rsvd;
        logic        crc_err;
        logic [12:0] len;
        logic [10:0] unused;
        logic [2:0]  l4_type;
        logic        l3_err;
        logic        l4_err;
    } meta_word_t;

endpackage

// ----- rtl/core/usbdfr_store.sv -----
// byte store of the deframer: one write port, one registered read port
module usbdfr_store #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/usb_rx_bundle_deframer.sv -----
// top level of the usb rx bundle deframer: byte load, trailer check, metadata walk
//
// s_ channel: one byte of a bulk transfer per beat, s_end_of_transfer on the final
// beat. bytes load at one per cycle into the byte store; bytes past the store
// depth are dropped and the transfer is rejected.
// after the final beat s_ready stays low while the metadata walk runs; it
// reads the store one byte per cycle through its single read port.
// walk steps: bounds check, trailer read, header check, then per metadata
// entry a bounds check, a 4-byte read and an evaluation, then the status
// beat. a rejected transfer goes straight to status.
// m_ channel: one beat per good packet (start, length, checksum flag), then a
// status beat with m_last high and m_transfer_ok set if the final entry was
// delivered. results sit in an output register; while it is still full and
// m_ready is low the walk holds and resumes when the register is taken. the
// next transfer starts loading while the status beat still waits.
// reset: synchronous, active low; clears the byte count, overflow flag, state
// and output valid. the store itself is not cleared.
module usb_rx_bundle_deframer #(
    parameter int BUF_BYTES = usbdfr_pkg::BUF_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_transfer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_packet,
    output logic [14:0] m_pkt_start,
    output logic [12:0] m_pkt_length,
    output logic        m_checksum_ok,
    output logic        m_transfer_ok,
    output logic        m_last
);
    import usbdfr_pkg::*;

    localparam int          ADDR_W  = $clog2(BUF_BYTES);
    localparam logic [15:0] BUF_LIM = 16'(BUF_BYTES);

    dfr_state_t state_reg, state_next;

    logic [15:0]        count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [2:0]         rd_cnt_reg, rd_cnt_next;
    logic [ADDR_W-1:0]  rd_base_reg, rd_base_next;
    logic [31:0]        word_reg, word_next;
    logic [15:0]        hoff_reg, hoff_next;
    logic [ENTRY_W-1:0] ent_cnt_reg, ent_cnt_next;
    logic [ENTRY_W-1:0] idx_reg, idx_next;
    logic [15:0]        cur_reg, cur_next;
    logic               ok_reg, ok_next;

    logic               m_valid_reg, m_valid_next;
    logic               is_packet_reg, is_packet_next;
    logic [14:0]        pkt_start_reg, pkt_start_next;
    logic [12:0]        pkt_length_reg, pkt_length_next;
    logic               checksum_ok_reg, checksum_ok_next;
    logic               transfer_ok_reg, transfer_ok_next;
    logic               last_reg, last_next;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;

    logic               s_fire;
    logic               out_free;
    logic [15:0]        len;
    logic               hdr_bad;
    logic [16:0]        at;
    logic               at_bad;
    meta_word_t         meta;
    logic [15:0]        left;
    logic               overrun;
    logic               good;
    logic               final_ent;
    logic [13:0]        adv;
    logic               adv_bad;
    logic               ck;

    usbdfr_store #(
        .DEPTH (BUF_BYTES),
        .ADDR_W(ADDR_W)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(s_data_byte),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign s_ready  = (state_reg == ST_LOAD);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign len      = count_reg - 16'd4;

    // trailer checks
    assign hdr_bad = (word_reg[15:0] == 16'd0) || (word_reg[15:0] > MAX_ENTRIES_V) ||
                     (({1'b0, word_reg[15:0], 1'b0} + {2'b0, word_reg[31:16]}) >
                      {2'b0, len});

    // metadata entry position and bounds
    assign at     = {1'b0, hoff_reg} + {9'b0, idx_reg, 2'b0};
    assign at_bad = ({1'b0, at} + 18'd4) > {2'b0, len};

    // entry evaluation
    assign meta      = meta_word_t'(word_reg);
    assign left      = hoff_reg - cur_reg;
    assign overrun   = {3'b0, meta.len} > left;
    assign good      = !meta.crc_err && !meta.drop_err && (meta.len >= RUNT_MIN);
    assign final_ent = ({1'b0, idx_reg} + 7'd1) == {1'b0, ent_cnt_reg};
    assign adv       = ({1'b0, meta.len} + 14'd7) & 14'h3ff8;
    assign adv_bad   = {2'b0, adv} > left;
    assign ck        = !meta.l3_err && !meta.l4_err &&
                       ((meta.l4_type == L4_TYPE_TCP) || (meta.l4_type == L4_TYPE_UDP));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_end_of_transfer) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (ovf_reg || (count_reg < 16'd4)) begin
                    state_next = ST_STATUS;
                end else begin
                    state_next = ST_TRAIL;
                end
            end
            ST_TRAIL: begin
                if (rd_cnt_reg == WORD_BYTES) begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                state_next = hdr_bad ? ST_STATUS : ST_ENTRY;
            end
            ST_ENTRY: begin
                state_next = at_bad ? ST_STATUS : ST_META;
            end
            ST_META: begin
                if (rd_cnt_reg == WORD_BYTES) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_free) begin
                    if (overrun || final_ent || adv_bad) begin
                        state_next = ST_STATUS;
                    end else begin
                        state_next = ST_ENTRY;
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        rd_cnt_next      = rd_cnt_reg;
        rd_base_next     = rd_base_reg;
        word_next        = word_reg;
        hoff_next        = hoff_reg;
        ent_cnt_next     = ent_cnt_reg;
        idx_next         = idx_reg;
        cur_next         = cur_reg;
        ok_next          = ok_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        is_packet_next   = is_packet_reg;
        pkt_start_next   = pkt_start_reg;
        pkt_length_next  = pkt_length_reg;
        checksum_ok_next = checksum_ok_reg;
        transfer_ok_next = transfer_ok_reg;
        last_next        = last_reg;
        wr_en            = 1'b0;
        wr_addr          = ADDR_W'(count_reg);
        rd_en            = 1'b0;
        rd_addr          = rd_base_reg + ADDR_W'(rd_cnt_reg[1:0]);
        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (count_reg < BUF_LIM) begin
                        wr_en = 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (count_reg != 16'hffff) begin
                        count_next = count_reg + 16'd1;
                    end
                    ok_next = 1'b0;
                end
            end
            ST_START: begin
                rd_base_next = ADDR_W'(len);
                rd_cnt_next  = 3'd0;
            end
            ST_TRAIL, ST_META: begin
                // little-endian gather, one byte per cycle
                if (rd_cnt_reg != WORD_BYTES) begin
                    rd_en       = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 3'd1;
                end else begin
                    rd_cnt_next = 3'd0;
                end
                if (rd_cnt_reg != 3'd0) begin
                    word_next = {rd_data, word_reg[31:8]};
                end
            end
            ST_HDR: begin
                hoff_next    = word_reg[31:16];
                ent_cnt_next = word_reg[ENTRY_W-1:0];
                idx_next     = '0;
                cur_next     = 16'd0;
            end
            ST_ENTRY: begin
                rd_base_next = ADDR_W'(at);
                rd_cnt_next  = 3'd0;
            end
            ST_EVAL: begin
                if (out_free && !overrun) begin
                    if (good) begin
                        m_valid_next     = 1'b1;
                        is_packet_next   = 1'b1;
                        pkt_start_next   = 15'(cur_reg + 16'd2);
                        pkt_length_next  = meta.len - PAD_BYTES;
                        checksum_ok_next = ck;
                        transfer_ok_next = 1'b0;
                        last_next        = 1'b0;
                    end
                    if (final_ent) begin
                        ok_next = good;
                    end else if (!adv_bad) begin
                        cur_next = cur_reg + {2'b0, adv};
                        idx_next = idx_reg + ENTRY_W'(1);
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    is_packet_next   = 1'b0;
                    pkt_start_next   = 15'd0;
                    pkt_length_next  = 13'd0;
                    checksum_ok_next = 1'b0;
                    transfer_ok_next = ok_reg;
                    last_next        = 1'b1;
                    count_next       = 16'd0;
                    ovf_next         = 1'b0;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= 16'd0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            rd_cnt_reg  <= 3'd0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            rd_cnt_reg  <= rd_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_base_reg     <= rd_base_next;
        word_reg        <= word_next;
        hoff_reg        <= hoff_next;
        ent_cnt_reg     <= ent_cnt_next;
        idx_reg         <= idx_next;
        cur_reg         <= cur_next;
        ok_reg          <= ok_next;
        is_packet_reg   <= is_packet_next;
        pkt_start_reg   <= pkt_start_next;
        pkt_length_reg  <= pkt_length_next;
        checksum_ok_reg <= checksum_ok_next;
        transfer_ok_reg <= transfer_ok_next;
        last_reg        <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_is_packet   = is_packet_reg;
    assign m_pkt_start   = pkt_start_reg;
    assign m_pkt_length  = pkt_length_reg;
    assign m_checksum_ok = checksum_ok_reg;
    assign m_transfer_ok = transfer_ok_reg;
    assign m_last        = last_reg;

endmodule

// ----- tb/sv/usb_rx_bundle_deframer_test.sv -----
// self-checking testbench for the usb rx bundle deframer: bundle stimulus, descriptor scoreboard
module usb_rx_bundle_deframer_test;
    import usbdfr_pkg::*;

    localparam int BUF = BUF_BYTES_DEF;

    typedef struct packed {
        logic        is_packet;
        logic [14:0] pkt_start;
        logic [12:0] pkt_length;
        logic        checksum_ok;
        logic        transfer_ok;
        logic        last;
    } desc_t;

    class deframe_board;
        logic [7:0]  store [BUF];
        int unsigned byte_count = 0;
        bit          overflowed = 0;
        desc_t       desc_q [$];
        int          errors = 0;
        int          seen = 0;

        function logic [7:0] peek(logic [31:0] i);
            return (i < BUF) ? store[i[14:0]] : 8'h00;
        endfunction

        function logic [31:0] peek_word(logic [31:0] i);
            return {peek(i + 3), peek(i + 2), peek(i + 1), peek(i)};
        endfunction

        // queues the descriptors of the stored bundle, returns 1 if the final entry went out
        function bit walk_bundle();
            logic [31:0] len, trailer, cnt, hoff, cur, at, plen, left, adv;
            meta_word_t  m;
            bit          fin;
            bit          ck;
            if (overflowed || byte_count < 4) return 1'b0;
            len = byte_count - 4;
            trailer = peek_word(len);
            cnt = {16'd0, trailer[15:0]};
            hoff = {16'd0, trailer[31:16]};
            if (cnt == 0 || cnt > MAX_ENTRIES) return 1'b0;
            if (cnt * 2 + hoff > len) return 1'b0;
            cur = 0;
            for (int unsigned i = 0; i < cnt; i++) begin
                at = hoff + 4 * i;
                fin = (i + 1 == cnt);
                if (at + 4 > len) return 1'b0;
                m = peek_word(at);
                plen = {19'd0, m.len};
                left = hoff - cur;
                if (plen > left) return 1'b0;
                if (!m.crc_err && !m.drop_err && m.len >= RUNT_MIN) begin
                    ck = !m.l3_err && !m.l4_err &&
                         (m.l4_type == L4_TYPE_TCP || m.l4_type == L4_TYPE_UDP);
                    desc_q.push_back('{is_packet: 1'b1, pkt_start: 15'(cur + 2),
                                       pkt_length: 13'(plen - 2), checksum_ok: ck,
                                       transfer_ok: 1'b0, last: 1'b0});
                    if (fin) return 1'b1;
                end
                if (fin) return 1'b0;
                adv = (plen + 7) & 32'hFFF8;
                if (adv > left) return 1'b0;
                cur += adv;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, logic eot);
            bit ok;
            if (byte_count < BUF) store[byte_count] = b;
            else overflowed = 1'b1;
            if (byte_count < 65535) byte_count++;
            if (eot) begin
                ok = walk_bundle();
                desc_q.push_back('{is_packet: 1'b0, pkt_start: '0, pkt_length: '0,
                                   checksum_ok: 1'b0, transfer_ok: ok, last: 1'b1});
                byte_count = 0;
                overflowed = 1'b0;
            end
        endfunction

        function int pending();
            return desc_q.size();
        endfunction

        task report_mismatch(string msg);
            if (errors < 200) $display("ERROR: %s", msg);
            errors++;
        endtask

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                          seen, name, got, want));
        endtask

        task check_result(desc_t got);
            desc_t want;
            if (desc_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected: %p", seen, got));
                seen++;
                return;
            end
            want = desc_q.pop_front();
            cmp_field("is_packet", 32'(got.is_packet), 32'(want.is_packet));
            cmp_field("pkt_start", 32'(got.pkt_start), 32'(want.pkt_start));
            cmp_field("pkt_length", 32'(got.pkt_length), 32'(want.pkt_length));
            cmp_field("checksum_ok", 32'(got.checksum_ok), 32'(want.checksum_ok));
            cmp_field("transfer_ok", 32'(got.transfer_ok), 32'(want.transfer_ok));
            cmp_field("last", 32'(got.last), 32'(want.last));
            seen++;
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_end_of_transfer = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_is_packet;
    logic [14:0] m_pkt_start;
    logic [12:0] m_pkt_length;
    logic        m_checksum_ok;
    logic        m_transfer_ok;
    logic        m_last;

    deframe_board board = new();

    int          send_idle = 0;
    int          recv_stall = 0;
    bit          hold_go = 1'b0;
    logic        hold_on = 1'b0;
    logic [7:0]  xfer [$];
    logic [31:0] metas [$];

    int send_pct [4] = '{0, 73, 0, 26};
    int recv_pct [4] = '{0, 0, 73, 26};

    always #10 aclk = ~aclk;

    usb_rx_bundle_deframer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_transfer (s_end_of_transfer),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_is_packet       (m_is_packet),
        .m_pkt_start       (m_pkt_start),
        .m_pkt_length      (m_pkt_length),
        .m_checksum_ok     (m_checksum_ok),
        .m_transfer_ok     (m_transfer_ok),
        .m_last            (m_last)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_is_packet, m_pkt_start, m_pkt_length,
                                 m_checksum_ok, m_transfer_ok, m_last});
        if (!aresetn || hold_on) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // long receiver hold-off so the walk stalls and the input backs up
    initial begin : long_hold
        wait (hold_go);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (3000) @(posedge aclk);
        hold_on <= 1'b0;
    end

    task automatic send_beat(input logic [7:0] b, input logic eot);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_end_of_transfer <= eot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_byte(b, eot);
    endtask

    task automatic send_xfer();
        foreach (xfer[i]) send_beat(xfer[i], i == xfer.size() - 1);
    endtask

    task automatic put_random_bytes(input int n);
        repeat (n) xfer.push_back(8'($urandom));
    endtask

    task automatic add_meta(input int len, input logic [2:0] ty, input logic [1:0] errs,
                            input logic crc, input logic drop);
        meta_word_t m;
        m = $urandom;
        m.len = 13'(len);
        m.l4_type = ty;
        {m.l3_err, m.l4_err} = errs;
        m.crc_err = crc;
        m.drop_err = drop;
        metas.push_back(m);
    endtask

    function automatic int layout_len();
        int total;
        total = 0;
        foreach (metas[i])
            total += (i == metas.size() - 1) ? int'(metas[i][28:16])
                                             : (int'(metas[i][28:16]) + 7) & 'hFFF8;
        return total;
    endfunction

    // payload, metadata words, optional pad, then the trailer
    task automatic build_bundle(input int payload_len, input int tail_pad, input int cnt_field);
        int          plen;
        int          cnt;
        logic [31:0] trailer;
        plen = (payload_len < 0) ? layout_len() : payload_len;
        cnt = (cnt_field < 0) ? metas.size() : cnt_field;
        xfer.delete();
        put_random_bytes(plen);
        foreach (metas[i])
            for (int k = 0; k < 4; k++) xfer.push_back(metas[i][8 * k +: 8]);
        put_random_bytes(tail_pad);
        trailer = {16'(plen), 16'(cnt)};
        for (int k = 0; k < 4; k++) xfer.push_back(trailer[8 * k +: 8]);
    endtask

    function automatic logic [31:0] rand_meta();
        meta_word_t m;
        int         r;
        m = $urandom;
        r = $urandom_range(99);
        if (r < 25) m.len = 13'($urandom_range(15));
        else m.len = 13'($urandom_range(24, 16));
        m.crc_err = ($urandom_range(9) == 0);
        m.drop_err = ($urandom_range(9) == 0);
        if ($urandom_range(1)) begin
            m.l3_err = 1'b0;
            m.l4_err = 1'b0;
            m.l4_type = $urandom_range(1) ? L4_TYPE_TCP : L4_TYPE_UDP;
        end
        return m;
    endfunction

    task automatic random_transfer();
        int kind;
        int n;
        int plen;
        kind = $urandom_range(99);
        n = ($urandom_range(3) == 0) ? 2 : 1;
        metas.delete();
        repeat (n) metas.push_back(rand_meta());
        if (kind < 60) begin
            build_bundle(-1, ($urandom_range(3) == 0) ? $urandom_range(3) : 0, -1);
        end else if (kind < 70) begin
            build_bundle(-1, $urandom_range(3), $urandom_range(70));
        end else if (kind < 80) begin
            plen = layout_len() - $urandom_range(8, 1);
            build_bundle((plen < 0) ? 0 : plen, 0, -1);
        end else if (kind < 88) begin
            build_bundle(-1, 0, n + $urandom_range(3, 1));
        end else begin
            xfer.delete();
            put_random_bytes($urandom_range(8, 1));
        end
        send_xfer();
    endtask

    task automatic directed_part();
        // short transfers
        xfer.delete();
        put_random_bytes(1);
        send_xfer();
        xfer.delete();
        put_random_bytes(3);
        send_xfer();
        // trailer only: zero count, a count with no room, a count above the entry limit
        metas.delete();
        build_bundle(0, 0, 0);
        send_xfer();
        build_bundle(0, 0, 1);
        send_xfer();
        build_bundle(0, 0, MAX_ENTRIES + 1);
        send_xfer();
        // good packet with an l3 error, then a final entry with a crc error
        metas.delete();
        add_meta(16, L4_TYPE_UDP, 2'b10, 1'b0, 1'b0);
        add_meta(0, L4_TYPE_TCP, 2'b00, 1'b1, 1'b0);
        build_bundle(-1, 2, -1);
        send_xfer();
        // single entry with a drop error
        metas.delete();
        add_meta(0, L4_TYPE_UDP, 2'b00, 1'b0, 1'b1);
        build_bundle(-1, 0, -1);
        send_xfer();
        // runts in the middle and at the end
        metas.delete();
        add_meta(7, L4_TYPE_UDP, 2'b00, 1'b0, 1'b0);
        add_meta(0, L4_TYPE_TCP, 2'b00, 1'b0, 1'b0);
        build_bundle(-1, 0, -1);
        send_xfer();
        // metadata word running into the trailer
        metas.delete();
        add_meta(16, L4_TYPE_TCP, 2'b00, 1'b0, 1'b0);
        add_meta(0, L4_TYPE_TCP, 2'b00, 1'b0, 1'b0);
        add_meta(0, L4_TYPE_UDP, 2'b00, 1'b0, 1'b0);
        build_bundle(-1, 0, 4);
        send_xfer();
        // length overrun
        metas.delete();
        add_meta(16, L4_TYPE_TCP, 2'b00, 1'b0, 1'b0);
        add_meta(20, L4_TYPE_TCP, 2'b00, 1'b0, 1'b0);
        build_bundle(16, 0, -1);
        send_xfer();
        // advance overrun
        metas.delete();
        add_meta(17, L4_TYPE_UDP, 2'b00, 1'b0, 1'b0);
        add_meta(0, L4_TYPE_UDP, 2'b00, 1'b0, 1'b0);
        build_bundle(17, 0, -1);
        send_xfer();
    endtask

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_part();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = send_pct[ph];
            recv_stall = recv_pct[ph];
            if (ph == 0) hold_go = 1'b1;
            repeat (2) random_transfer();
        end
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
